// ----- rtl/date_add_subtract_days_macros.svh -----
// ----------------------------------------------------------------------------
// date_add_subtract_days_macros
// assertion macros used by the checker file dasd_checker.sv
// ----------------------------------------------------------------------------
`ifndef DATE_ADD_SUBTRACT_DAYS_MACROS_SVH
`define DATE_ADD_SUBTRACT_DAYS_MACROS_SVH

// same-cycle implication
`define DASD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dasd assertion failed");

// next-cycle implication
`define DASD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dasd assertion failed");

`endif

// ----- rtl/dasd_pkg.sv -----
// ----------------------------------------------------------------------------
// dasd_pkg
// types, constants and the month-length table of the date add/subtract block
// ----------------------------------------------------------------------------
`default_nettype none

package dasd_pkg;

  localparam int DAY_W        = 5;
  localparam int MONTH_W      = 4;
  localparam int YEAR_W       = 16;
  localparam int DAY_COUNT_W  = 16;
  localparam int COUNT_BITS   = 16;
  localparam int DIV_BITS     = (COUNT_BITS < DAY_COUNT_W) ? COUNT_BITS : DAY_COUNT_W;
  localparam int DAYS_PER_YEAR = 365;
  localparam int REM_W        = $clog2(DAYS_PER_YEAR);
  localparam int MONTHS       = 12;
  localparam int INVALID_MONTH_LEN = 31;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  // ceil(2^24 / 365), exact quotient for counts up to 16 bits
  localparam int RECIP_365    = 45965;
  localparam int RECIP_W      = 16;
  localparam int RECIP_SHIFT  = 24;
  localparam int PROD_W       = DIV_BITS + RECIP_W;

  localparam logic [DAY_W-1:0]   RESET_DAY   = DAY_W'(1);
  localparam logic [MONTH_W-1:0] RESET_MONTH = MONTH_W'(1);
  localparam logic [YEAR_W-1:0]  RESET_YEAR  = YEAR_W'(1998);

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_SUB = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_DAY   = 2'd0,
    REG_START_MONTH = 2'd1,
    REG_START_YEAR  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_YEAR,
    ST_STEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic div_step;
    logic year_apply;
    logic day_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic rest_zero;
  } status_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1:    len = DAY_W'(31);
      4'd2:    len = DAY_W'(28);
      4'd3:    len = DAY_W'(31);
      4'd4:    len = DAY_W'(30);
      4'd5:    len = DAY_W'(31);
      4'd6:    len = DAY_W'(30);
      4'd7:    len = DAY_W'(31);
      4'd8:    len = DAY_W'(31);
      4'd9:    len = DAY_W'(30);
      4'd10:   len = DAY_W'(31);
      4'd11:   len = DAY_W'(30);
      4'd12:   len = DAY_W'(31);
      default: len = DAY_W'(INVALID_MONTH_LEN);
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dasd_if.sv -----
// ----------------------------------------------------------------------------
// dasd_cmd_if / dasd_result_if
// valid/ready channels carrying a day-count request and a resulting date
// ----------------------------------------------------------------------------
`default_nettype none

interface dasd_cmd_if;
  import dasd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [DAY_COUNT_W-1:0] day_count;
  modport source (output valid, output operation, output day_count, input ready);
  modport sink   (input valid, input operation, input day_count, output ready);
endinterface

interface dasd_result_if;
  import dasd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic        [DAY_W-1:0]   out_day;
  logic        [MONTH_W-1:0] out_month;
  logic signed [YEAR_W-1:0]  out_year;
  modport source (output valid, output out_day, output out_month, output out_year,
                  input ready);
  modport sink   (input valid, input out_day, input out_month, input out_year,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/date_add_subtract_days.sv -----
// ----------------------------------------------------------------------------
// date_add_subtract_days
// adds or subtracts a day count to a stored date in a 365-day calendar
// ----------------------------------------------------------------------------
// cmd channel: operation (0 add, 1 subtract) and day_count; result channel:
// out_day, out_month, out_year, the current date after the item.
// cfg port: cfg_we, cfg_index (0 day, 1 month, 2 year), cfg_data; any write
// of registers 0..2 also reloads the current date from the start values.
// one item at a time: a reciprocal multiply by 365 gives the whole years,
// the next cycle updates the year and loads the leftover days,
// then the day stepper walks the leftover days one per cycle.
// a new item is taken the cycle after the result is loaded.
// the result sits in an output register, so the next item is accepted while
// an earlier result waits; an item only stalls at its end if the receiver
// still holds off the previous result.
// reset: date goes to 1/1/1998, no result pending, cmd ready.
// ----------------------------------------------------------------------------
`default_nettype none

module date_add_subtract_days (
  input  wire logic                            clk,
  input  wire logic                            rst,
  dasd_cmd_if.sink                             cmd,
  dasd_result_if.source                        result,
  input  wire logic                            cfg_we,
  input  wire logic [dasd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [dasd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dasd_pkg::*;

  cmd_t                 dp_cmd;
  status_t              dp_status;
  logic [YEAR_W-1:0]    year_q;

  dasd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (dp_cmd),
    .status    (dp_status)
  );

  dasd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (dp_cmd),
    .status    (dp_status),
    .operation (cmd.operation),
    .day_count (cmd.day_count),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_day   (result.out_day),
    .out_month (result.out_month),
    .out_year  (year_q)
  );

  assign result.out_year = year_q;

endmodule

`default_nettype wire

// ----- rtl/dasd_datapath.sv -----
// ----------------------------------------------------------------------------
// dasd_datapath
// start/current date registers, reciprocal divide by 365, day stepper
// ----------------------------------------------------------------------------
`default_nettype none

module dasd_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire dasd_pkg::cmd_t                  cmd,
  output dasd_pkg::status_t                    status,
  input  wire logic                            operation,
  input  wire logic [dasd_pkg::DAY_COUNT_W-1:0] day_count,
  input  wire logic                            cfg_we,
  input  wire logic [dasd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [dasd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic      [dasd_pkg::DAY_W-1:0]      out_day,
  output logic      [dasd_pkg::MONTH_W-1:0]    out_month,
  output logic      [dasd_pkg::YEAR_W-1:0]     out_year
);
  import dasd_pkg::*;

  logic [DAY_W-1:0]     start_day, start_day_next;
  logic [MONTH_W-1:0]   start_month, start_month_next;
  logic [YEAR_W-1:0]    start_year, start_year_next;
  logic                 cfg_hit;
  logic [DAY_W-1:0]     cur_day, step_day;
  logic [MONTH_W-1:0]   cur_month, step_month;
  logic [YEAR_W-1:0]    cur_year, step_year;
  logic [DIV_BITS-1:0]  dividend;
  logic [REM_W-1:0]     rem;
  logic [YEAR_W-1:0]    quot;
  logic                 sub_op;
  logic [PROD_W-1:0]    recip_prod;
  logic [DIV_BITS-1:0]  whole_days;
  logic [DIV_BITS-1:0]  leftover;
  logic [DAY_W-1:0]     len_cur;
  logic [DAY_W-1:0]     len_prev;

  // config write
  always_comb begin
    start_day_next   = start_day;
    start_month_next = start_month;
    start_year_next  = start_year;
    cfg_hit          = 1'b0;
    unique case (cfg_reg_t'(cfg_index))
      REG_START_DAY: begin
        start_day_next = cfg_data[DAY_W-1:0];
        cfg_hit        = 1'b1;
      end
      REG_START_MONTH: begin
        start_month_next = cfg_data[MONTH_W-1:0];
        cfg_hit          = 1'b1;
      end
      REG_START_YEAR: begin
        start_year_next = cfg_data[YEAR_W-1:0];
        cfg_hit         = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_day   <= RESET_DAY;
      start_month <= RESET_MONTH;
      start_year  <= RESET_YEAR;
    end else if (cfg_we) begin
      start_day   <= start_day_next;
      start_month <= start_month_next;
      start_year  <= start_year_next;
    end
  end

  // whole years by reciprocal multiply, leftover days in the following cycle
  assign recip_prod = PROD_W'(dividend) * PROD_W'(RECIP_365);
  assign whole_days = quot[DIV_BITS-1:0] * DIV_BITS'(DAYS_PER_YEAR);
  assign leftover   = dividend - whole_days;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dividend <= day_count[DIV_BITS-1:0];
      sub_op   <= operation;
    end else if (cmd.div_step) begin
      quot     <= YEAR_W'(recip_prod[PROD_W-1:RECIP_SHIFT]);
    end else if (cmd.year_apply) begin
      rem      <= leftover[REM_W-1:0];
    end else if (cmd.day_step) begin
      rem      <= rem - 1'b1;
    end
  end

  assign status.rest_zero = (rem == '0);

  // one calendar day forward or backward
  assign len_cur  = month_len(cur_month);
  assign len_prev = month_len(cur_month - 1'b1);

  always_comb begin
    step_day   = cur_day;
    step_month = cur_month;
    step_year  = cur_year;
    if (sub_op == OP_SUB) begin
      priority if (cur_day > DAY_W'(1)) begin
        step_day = cur_day - 1'b1;
      end else if (cur_day == DAY_W'(1) && cur_month > MONTH_W'(1)) begin
        step_day   = len_prev;
        step_month = cur_month - 1'b1;
      end else if (cur_day == DAY_W'(1) && cur_month == MONTH_W'(1)) begin
        step_day   = DAY_W'(INVALID_MONTH_LEN);
        step_month = MONTH_W'(MONTHS);
        step_year  = cur_year - 1'b1;
      end else begin
        step_day = cur_day;
      end
    end else begin
      priority if (cur_day < len_cur) begin
        step_day = cur_day + 1'b1;
      end else if (cur_day == len_cur && cur_month < MONTH_W'(MONTHS)) begin
        step_day   = DAY_W'(1);
        step_month = cur_month + 1'b1;
      end else if (cur_day == len_cur && cur_month == MONTH_W'(MONTHS)) begin
        step_day   = DAY_W'(1);
        step_month = MONTH_W'(1);
        step_year  = cur_year + 1'b1;
      end else begin
        step_day = cur_day;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_day   <= RESET_DAY;
      cur_month <= RESET_MONTH;
      cur_year  <= RESET_YEAR;
    end else if (cfg_we && cfg_hit) begin
      cur_day   <= start_day_next;
      cur_month <= start_month_next;
      cur_year  <= start_year_next;
    end else if (cmd.year_apply) begin
      cur_year  <= (sub_op == OP_SUB) ? cur_year - quot : cur_year + quot;
    end else if (cmd.day_step) begin
      cur_day   <= step_day;
      cur_month <= step_month;
      cur_year  <= step_year;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_day   <= cur_day;
      out_month <= cur_month;
      out_year  <= cur_year;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dasd_ctrl.sv -----
// ----------------------------------------------------------------------------
// dasd_ctrl
// sequencer for divide, year update, day stepping and result handoff
// ----------------------------------------------------------------------------
`default_nettype none

module dasd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dasd_pkg::cmd_t         cmd,
  input  wire dasd_pkg::status_t status
);
  import dasd_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DIVIDE;
      ST_DIVIDE: state_next = ST_YEAR;
      ST_YEAR:   state_next = ST_STEP;
      ST_STEP:   if (status.rest_zero) state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_DIVIDE: cmd.div_step   = 1'b1;
      ST_YEAR:   cmd.year_apply = 1'b1;
      ST_STEP:   cmd.day_step   = !status.rest_zero;
      ST_DONE:   cmd.out_load   = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    priority if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dasd_checker.sv -----
// ----------------------------------------------------------------------------
// dasd_checker
// port-level checks of the date add/subtract block, bound to the top level
// ----------------------------------------------------------------------------
`include "date_add_subtract_days_macros.svh"
`default_nettype none

module dasd_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [dasd_pkg::DAY_W-1:0]   out_day,
  input wire logic [dasd_pkg::MONTH_W-1:0] out_month,
  input wire logic [dasd_pkg::YEAR_W-1:0]  out_year
);
  import dasd_pkg::*;

  `DASD_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `DASD_ASSERT_NEXT(a_no_result_right_after_accept, clk, rst, in_valid && in_ready,
                    !$rose(out_valid))
  `DASD_ASSERT_NOW(a_ready_with_new_result, clk, rst, $rose(out_valid), in_ready)
  `DASD_ASSERT_NEXT(a_result_held, clk, rst, out_valid && !out_ready,
                    out_valid && $stable(out_day) && $stable(out_month) && $stable(out_year))

endmodule

bind date_add_subtract_days dasd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (cmd.valid),
  .in_ready  (cmd.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_day   (result.out_day),
  .out_month (result.out_month),
  .out_year  (result.out_year)
);

`default_nettype wire

// ----- bench/tb_date_add_subtract_days.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_date_add_subtract_days
// self-checking bench for the 365-day calendar add/subtract block
// ----------------------------------------------------------------------------
// a driver and a monitor in clocked always blocks work the two valid/ready
// channels; an initial block loads start dates through the register port and
// fills the queue of pending day-count requests. every accepted request runs
// through a local date model whose new date is queued and compared field by
// field with the next result. directed requests cover the field extremes,
// both operations, year wrap, stuck days past the month end, day zero,
// months outside 1..12 and an ignored register index; random phases follow,
// first with sparse sender gaps and heavy receiver stalls, then the reverse,
// then with no gaps and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_date_add_subtract_days;
  import dasd_pkg::*;

  localparam int STALL_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 3000;
  localparam int SETTLE_CYCLES = 400;
  localparam int PHASES        = 30;
  localparam int PHASE_ITEMS   = 34;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = CFG_INDEX_W'(3);
  localparam logic [0:11][DAY_W-1:0] MONTH_LENGTHS = {
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    op_t                    op;
    logic [DAY_COUNT_W-1:0] count;
  } day_request_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  dasd_cmd_if    cmd_ch ();
  dasd_result_if res_ch ();

  date_add_subtract_days dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .result    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  day_request_t pending_requests[$];
  date_t        expected_dates[$];
  day_request_t next_request;
  date_t        oldest_date;

  logic [DAY_W-1:0]   load_day   = RESET_DAY;
  logic [MONTH_W-1:0] load_month = RESET_MONTH;
  logic [YEAR_W-1:0]  load_year  = RESET_YEAR;
  logic [DAY_W-1:0]   date_day   = RESET_DAY;
  logic [MONTH_W-1:0] date_month = RESET_MONTH;
  logic [YEAR_W-1:0]  date_year  = RESET_YEAR;

  int send_gap_pct     = 0;
  int recv_gap_pct     = 0;
  int hold_requests    = 0;
  int holds_granted    = 0;
  int hold_cycles_left = 0;
  int mismatches       = 0;
  int quiet_cycles     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [DAY_W-1:0] days_in_month(logic [MONTH_W-1:0] m);
    if (m >= 1 && m <= MONTHS) begin
      return MONTH_LENGTHS[m - 1];
    end
    return DAY_W'(INVALID_MONTH_LEN);
  endfunction

  function automatic void day_forward();
    logic [DAY_W-1:0] len;
    len = days_in_month(date_month);
    if (date_day < len) begin
      date_day = date_day + 1'b1;
    end else if (date_day == len && date_month < MONTHS) begin
      date_day   = DAY_W'(1);
      date_month = date_month + 1'b1;
    end else if (date_day == len && date_month == MONTHS) begin
      date_day   = DAY_W'(1);
      date_month = MONTH_W'(1);
      date_year  = date_year + 1'b1;
    end
  endfunction

  function automatic void day_backward();
    if (date_day > 1) begin
      date_day = date_day - 1'b1;
    end else if (date_day == 1 && date_month > 1) begin
      date_day   = days_in_month(date_month - 1'b1);
      date_month = date_month - 1'b1;
    end else if (date_day == 1 && date_month == 1) begin
      date_day   = DAY_W'(31);
      date_month = MONTH_W'(MONTHS);
      date_year  = date_year - 1'b1;
    end
  endfunction

  function automatic void apply_day_count(op_t op, logic [DAY_COUNT_W-1:0] count);
    int unsigned whole_years;
    int unsigned leftover;
    date_t       d;
    whole_years = count / DAYS_PER_YEAR;
    leftover    = count % DAYS_PER_YEAR;
    if (op == OP_SUB) begin
      date_year = date_year - YEAR_W'(whole_years);
    end else begin
      date_year = date_year + YEAR_W'(whole_years);
    end
    repeat (leftover) begin
      if (op == OP_SUB) begin
        day_backward();
      end else begin
        day_forward();
      end
    end
    d.day   = date_day;
    d.month = date_month;
    d.year  = date_year;
    expected_dates.push_back(d);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < 100) begin
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  function automatic void queue_item(op_t op, logic [DAY_COUNT_W-1:0] count);
    day_request_t r;
    r.op    = op;
    r.count = count;
    pending_requests.push_back(r);
  endfunction

  function automatic logic [DAY_COUNT_W-1:0] random_count();
    int unsigned pick;
    int          k;
    pick = $urandom_range(9);
    case (pick)
      0, 1, 2, 3, 4: return DAY_COUNT_W'($urandom_range(0, 364));
      5, 6:          return DAY_COUNT_W'($urandom);
      7: begin
        k = $urandom_range(0, 179) * DAYS_PER_YEAR + $urandom_range(0, 2) - 1;
        if (k < 0) k = 0;
        return DAY_COUNT_W'(k);
      end
      8: begin
        case ($urandom_range(2))
          0:       return '0;
          1:       return '1;
          default: return DAY_COUNT_W'(364);
        endcase
      end
      default:       return DAY_COUNT_W'($urandom_range(0, 30));
    endcase
  endfunction

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    bit reload;
    reload = 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_START_DAY:   load_day   = data[DAY_W-1:0];
      REG_START_MONTH: load_month = data[MONTH_W-1:0];
      REG_START_YEAR:  load_year  = data[YEAR_W-1:0];
      default:         reload     = 1'b0;
    endcase
    if (reload) begin
      date_day   = load_day;
      date_month = load_month;
      date_year  = load_year;
    end
    @(negedge clk);
  endtask

  task automatic set_start_date(logic [DAY_W-1:0] day, logic [MONTH_W-1:0] month,
                                logic [YEAR_W-1:0] year);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[DAY_W-1:0] = day;
    write_reg(REG_START_DAY, d);
    d = CFG_DATA_W'($urandom);
    d[MONTH_W-1:0] = month;
    write_reg(REG_START_MONTH, d);
    write_reg(REG_START_YEAR, year);
  endtask

  task automatic wait_until_idle();
    @(negedge clk);
    while (pending_requests.size() != 0 || cmd_ch.valid || expected_dates.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        apply_day_count(op_t'(cmd_ch.operation), cmd_ch.day_count);
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          next_request = pending_requests.pop_front();
          cmd_ch.valid     <= 1'b1;
          cmd_ch.operation <= next_request.op;
          cmd_ch.day_count <= next_request.count;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_dates.size() == 0) begin
          report_mismatch("result with no item pending", res_ch.out_day, 0);
        end else begin
          oldest_date = expected_dates.pop_front();
          if (res_ch.out_day !== oldest_date.day) begin
            report_mismatch("out_day", res_ch.out_day, oldest_date.day);
          end
          if (res_ch.out_month !== oldest_date.month) begin
            report_mismatch("out_month", res_ch.out_month, oldest_date.month);
          end
          if (res_ch.out_year !== oldest_date.year) begin
            report_mismatch("out_year", $signed(res_ch.out_year),
                            $signed(oldest_date.year));
          end
        end
      end
      if (holds_granted != hold_requests) begin
        holds_granted++;
        hold_cycles_left = HOLD_CYCLES;
      end
      if (hold_cycles_left != 0) begin
        hold_cycles_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int                 phase;
    int unsigned        kind;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;

    rst              = 1'b1;
    cmd_ch.valid     = 1'b0;
    cmd_ch.operation = OP_ADD;
    cmd_ch.day_count = '0;
    res_ch.ready     = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_gap_pct = 9;
    recv_gap_pct = 73;

    // date after reset, count extremes
    queue_item(OP_ADD, 0);
    queue_item(OP_ADD, 1);
    queue_item(OP_ADD, 364);
    queue_item(OP_ADD, 365);
    queue_item(OP_SUB, 366);
    queue_item(OP_ADD, 16'hffff);
    queue_item(OP_SUB, 16'hffff);
    queue_item(OP_SUB, 0);

    // year wrap both ways
    wait_until_idle();
    set_start_date(5'd31, 4'd12, YEAR_W'(32767));
    queue_item(OP_ADD, 1);
    queue_item(OP_SUB, 1);
    wait_until_idle();
    set_start_date(5'd1, 4'd1, YEAR_W'(-32768));
    queue_item(OP_SUB, 1);
    queue_item(OP_ADD, 1);
    queue_item(OP_SUB, 365);

    // day past the month end
    wait_until_idle();
    set_start_date(5'd31, 4'd2, YEAR_W'(2000));
    queue_item(OP_ADD, 10);
    queue_item(OP_SUB, 5);

    // day zero
    wait_until_idle();
    set_start_date(5'd0, 4'd5, YEAR_W'(100));
    queue_item(OP_ADD, 3);
    wait_until_idle();
    write_reg(REG_START_DAY, '0);
    queue_item(OP_SUB, 3);

    // months outside 1..12
    wait_until_idle();
    set_start_date(5'd30, 4'd0, YEAR_W'(7));
    queue_item(OP_ADD, 3);
    wait_until_idle();
    write_reg(REG_START_DAY, CFG_DATA_W'(1));
    queue_item(OP_SUB, 1);
    wait_until_idle();
    set_start_date(5'd29, 4'd13, YEAR_W'(0));
    queue_item(OP_ADD, 5);
    wait_until_idle();
    set_start_date(5'd1, 4'd15, YEAR_W'(0));
    queue_item(OP_SUB, 1);

    // unused register index leaves the date alone
    wait_until_idle();
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    queue_item(OP_ADD, 0);

    for (phase = 0; phase < PHASES; phase++) begin
      wait_until_idle();
      if (phase < PHASES / 3) begin
        send_gap_pct = 9;
        recv_gap_pct = 73;
      end else if (phase < 2 * PHASES / 3) begin
        send_gap_pct = 73;
        recv_gap_pct = 9;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      if (phase == PHASES - 3) begin
        hold_requests++;
      end
      kind = $urandom_range(9);
      if (kind == 0) begin
        day   = DAY_W'($urandom);
        month = MONTH_W'($urandom);
        year  = YEAR_W'($urandom);
        set_start_date(day, month, year);
      end else if (kind == 1) begin
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
      end else if (kind != 9) begin
        month = MONTH_W'($urandom_range(1, MONTHS));
        day   = DAY_W'($urandom_range(1, days_in_month(month)));
        if (kind == 2) begin
          year = $urandom_range(1) ? YEAR_W'(32767 - $urandom_range(3))
                                   : YEAR_W'(-32768 + $urandom_range(3));
        end else begin
          year = YEAR_W'($urandom);
        end
        set_start_date(day, month, year);
      end
      repeat (PHASE_ITEMS) begin
        queue_item($urandom_range(1) ? OP_SUB : OP_ADD, random_count());
      end
    end

    wait_until_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_dates.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
